### src/ppte_pkg.sv
package ppte_pkg;

  localparam int unsigned SLOT_W = 12;
  localparam logic [15:0] EXPIRY_RESET = 16'd60;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] now_seconds;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] src_port;
    logic [63:0] probe_cookie;
  } query_t;

  typedef struct packed {
    logic              valid;
    logic              stop;
    logic              found;
    logic [SLOT_W-1:0] slot;
  } token_t;

endpackage

### src/ppte_cell.sv
module ppte_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ppte_pkg::query_t      query_i,
  input  logic [15:0]           expiry_i,
  input  ppte_pkg::token_t      tok_i,
  output ppte_pkg::token_t      tok_o,
  input  logic                  we_i,
  input  logic [ppte_pkg::SLOT_W-1:0] wslot_i
);

  ppte_pkg::token_t tok_q, tok_d;
  logic [31:0] start_q;
  logic [63:0] src_hi_q, src_lo_q, dst_hi_q, dst_lo_q, cookie_q;
  logic [15:0] port_q;
  logic        live, same, fresh, hit_cookie, wr;
  logic [31:0] age;

  assign wr         = we_i && (wslot_i == ppte_pkg::SLOT_W'(IDX));
  assign live       = (start_q != 32'd0);
  assign same       = (port_q == query_i.src_port) &&
                      (src_hi_q == query_i.src_addr_hi) && (src_lo_q == query_i.src_addr_lo) &&
                      (dst_hi_q == query_i.dst_addr_hi) && (dst_lo_q == query_i.dst_addr_lo);
  assign age        = query_i.now_seconds - start_q;
  assign fresh      = (query_i.now_seconds >= start_q) && (age <= {16'd0, expiry_i});
  assign hit_cookie = (cookie_q == query_i.probe_cookie);

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.stop) begin
      if (query_i.opcode == ppte_pkg::OP_INSERT) begin
        if (live && same) begin
          tok_d.stop  = 1'b1;
          tok_d.found = 1'b1;
          tok_d.slot  = ppte_pkg::SLOT_W'(IDX);
        end else if (!live || !fresh) begin
          tok_d.found = 1'b1;
          tok_d.slot  = ppte_pkg::SLOT_W'(IDX);
        end
      end else if (live && fresh && hit_cookie && same) begin
        tok_d.stop  = 1'b1;
        tok_d.found = 1'b1;
        tok_d.slot  = ppte_pkg::SLOT_W'(IDX);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      start_q <= 32'd0;
    end else begin
      tok_q <= tok_d;
      if (wr) begin
        start_q <= query_i.now_seconds;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      src_hi_q <= query_i.src_addr_hi;
      src_lo_q <= query_i.src_addr_lo;
      dst_hi_q <= query_i.dst_addr_hi;
      dst_lo_q <= query_i.dst_addr_lo;
      port_q   <= query_i.src_port;
      cookie_q <= query_i.probe_cookie;
    end
  end

  assign tok_o = tok_q;

endmodule

### src/pending_probe_table_with_expiry.sv
// One item at a time: in_stall_o is high from the accepted beat until the result is issued,
// so no new item is taken before the last is done; refused items skip the scan. The scan token
// walks the chain of entry cells one cell per cycle, and for an insert the chosen entry is
// written from the registered write enable that is set when S_DONE issues the result.
// Reset: all entries free, expiry_seconds 60, no result pending; entries are usable at once.
module pending_probe_table_with_expiry #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [31:0] now_seconds_i,
  input  logic [63:0] src_addr_hi_i,
  input  logic [63:0] src_addr_lo_i,
  input  logic [63:0] dst_addr_hi_i,
  input  logic [63:0] dst_addr_lo_i,
  input  logic [15:0] src_port_i,
  input  logic [63:0] probe_cookie_i,
  input  logic        packet_ok_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        success_o,
  output logic [7:0]  slot_index_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_e;

  state_e                       state_q;
  ppte_pkg::query_t             query_q;
  logic [15:0]                  expiry_q;
  logic                         start_q, we_q, res_found_q, out_valid_q, success_q;
  logic [ppte_pkg::SLOT_W-1:0]  res_slot_q;
  logic [7:0]                   slot_out_q;
  logic                         accept, refused;
  ppte_pkg::token_t             tok [TABLE_ENTRIES+1];

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign refused    = (opcode_i == ppte_pkg::OP_INSERT) ?
                      ((now_seconds_i == 32'd0) || (src_port_i == 16'd0)) : !packet_ok_i;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, expiry_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expiry_q <= ppte_pkg::EXPIRY_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      expiry_q <= pwdata[15:0];
    end
  end

  assign tok[0] = '{valid: start_q, stop: 1'b0, found: 1'b0, slot: '0};

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    ppte_cell #(.IDX(g)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .query_i  (query_q),
      .expiry_i (expiry_q),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1]),
      .we_i     (we_q),
      .wslot_i  (res_slot_q)
    );
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      query_q <= '{opcode: opcode_i, now_seconds: now_seconds_i,
                   src_addr_hi: src_addr_hi_i, src_addr_lo: src_addr_lo_i,
                   dst_addr_hi: dst_addr_hi_i, dst_addr_lo: dst_addr_lo_i,
                   src_port: src_port_i, probe_cookie: probe_cookie_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      we_q        <= 1'b0;
      res_found_q <= 1'b0;
      res_slot_q  <= '0;
      out_valid_q <= 1'b0;
      success_q   <= 1'b0;
      slot_out_q  <= 8'd0;
    end else begin
      start_q <= 1'b0;
      we_q    <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (refused) begin
              res_found_q <= 1'b0;
              state_q     <= S_DONE;
            end else begin
              start_q <= 1'b1;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (tok[TABLE_ENTRIES].valid) begin
            res_found_q <= tok[TABLE_ENTRIES].found;
            res_slot_q  <= tok[TABLE_ENTRIES].slot;
            state_q     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            success_q   <= res_found_q;
            slot_out_q  <= res_found_q ? res_slot_q[7:0] : 8'd0;
            we_q        <= res_found_q && (query_q.opcode == ppte_pkg::OP_INSERT);
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign success_o    = success_q;
  assign slot_index_o = slot_out_q;

endmodule
